@@ rtl/prow_pkg.sv @@
`default_nettype none

package prow_pkg;

  // field widths of the channels
  localparam int OP_W    = 3;
  localparam int POS_W   = 4;
  localparam int VAL_W   = 4;
  localparam int MASK_W  = 15;
  localparam int BC_W    = 5;
  localparam int ORDER_W = 16;

  localparam logic [BC_W-1:0]    BELL_COUNT_RST = 5'd16;
  localparam int                 MIN_BELLS      = 2;
  localparam logic [ORDER_W-1:0] ORDER_MAX      = 16'hFFFF;

  // divider step counter holds up to ORDER_W
  localparam int STEP_W = $clog2(ORDER_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_IDENTITY = 3'd0,
    OP_WRITE    = 3'd1,
    OP_READ     = 3'd2,
    OP_CHANGE   = 3'd3,
    OP_INVERT   = 3'd4,
    OP_ANALYSE  = 3'd5
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_EXEC,
    S_RD_CAP,
    S_CHG_LOAD,
    S_CHG_RD,
    S_CHG_WR,
    S_CHG_END,
    S_INV_RD,
    S_INV_WR,
    S_CPY_RD,
    S_CPY_WR,
    S_AN_SCAN,
    S_AN_STEP,
    S_AN_NEXT,
    S_LCM,
    S_GCD,
    S_QUO,
    S_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic [ORDER_W-1:0] perm_order;
    logic               is_even;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/prow_if.sv @@
`default_nettype none

interface prow_in_if import prow_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  bell_value;
  logic [MASK_W-1:0] swap_mask;

  modport source (output valid, output op, output position, output bell_value,
                  output swap_mask, input ready);
  modport sink (input valid, input op, input position, input bell_value,
                input swap_mask, output ready);
endinterface

interface prow_out_if import prow_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VAL_W-1:0]   read_value;
  logic [ORDER_W-1:0] perm_order;
  logic               is_even;
  logic               is_identity;

  modport source (output valid, output read_value, output perm_order, output is_even,
                  output is_identity, input ready);
  modport sink (input valid, input read_value, input perm_order, input is_even,
                input is_identity, output ready);
endinterface

interface prow_cfg_if import prow_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [BC_W-1:0] bell_count;

  modport source (output valid, output bell_count, input ready);
  modport sink (input valid, input bell_count, output ready);
endinterface

`default_nettype wire

@@ rtl/prow_store.sv @@
`default_nettype none

module prow_store import prow_pkg::*; #(
  parameter int MAX_BELLS = 16,
  localparam int IW = (MAX_BELLS > 1) ? $clog2(MAX_BELLS) : 1,
  localparam int EW = (IW > VAL_W) ? IW : VAL_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clear,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_addr,
  input  logic [EW-1:0]        wr_data,
  input  logic [IW-1:0]        rd_addr,
  output logic [EW-1:0]        rd_data,
  output logic [MAX_BELLS-1:0] mism
);

  logic [EW-1:0]        mem [MAX_BELLS];
  logic [MAX_BELLS-1:0] valid_r;
  logic [MAX_BELLS-1:0] mism_r;
  logic [EW-1:0]        rd_data_r;

  // an entry never written since the last clear reads as its own index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      mism_r  <= '0;
    end else if (clear) begin
      valid_r <= '0;
      mism_r  <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
      mism_r[wr_addr]  <= (wr_data != EW'(wr_addr));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : EW'(rd_addr);
  end

  assign rd_data = rd_data_r;
  assign mism    = mism_r;

endmodule

`default_nettype wire

@@ rtl/prow_div.sv @@
`default_nettype none

module prow_div import prow_pkg::*; #(
  parameter int DIVR_W = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  div_ctl_t           ctl,
  input  logic [ORDER_W-1:0] dividend,
  input  logic [DIVR_W-1:0]  divisor,
  output logic               done,
  output logic [ORDER_W-1:0] quot,
  output logic [DIVR_W-1:0]  rem
);

  logic [ORDER_W-1:0] quo_r;
  logic [DIVR_W-1:0]  rem_r;
  logic [DIVR_W-1:0]  dvs_r;
  logic [STEP_W-1:0]  cnt_r;
  logic               done_r;

  logic [DIVR_W:0]    trial;
  logic [DIVR_W:0]    diff;
  logic               ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_r, quo_r[ORDER_W-1]};
    ge    = (trial >= {1'b0, dvs_r});
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (ctl.start) begin
      cnt_r  <= ctl.steps;
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r  <= cnt_r - STEP_W'(1);
      done_r <= (cnt_r == STEP_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[ORDER_W-2:0], ge};
      rem_r <= ge ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ rtl/prow_seq.sv @@
`default_nettype none

module prow_seq import prow_pkg::*; #(
  parameter int MAX_BELLS = 16,
  localparam int IW = (MAX_BELLS > 1) ? $clog2(MAX_BELLS) : 1,
  localparam int EW = (IW > VAL_W) ? IW : VAL_W,
  localparam int NW = $clog2(MAX_BELLS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  // item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_op,
  input  logic [POS_W-1:0]   in_position,
  input  logic [VAL_W-1:0]   in_bell_value,
  input  logic [MASK_W-1:0]  in_swap_mask,
  input  logic [NW-1:0]      n,
  // row store
  output logic               row_clear,
  output logic               row_wr_en,
  output logic [IW-1:0]      row_wr_addr,
  output logic [EW-1:0]      row_wr_data,
  output logic [IW-1:0]      row_rd_addr,
  input  logic [EW-1:0]      row_rd_data,
  // scratch store for invert
  output logic               tmp_clear,
  output logic               tmp_wr_en,
  output logic [IW-1:0]      tmp_wr_addr,
  output logic [EW-1:0]      tmp_wr_data,
  output logic [IW-1:0]      tmp_rd_addr,
  input  logic [EW-1:0]      tmp_rd_data,
  // shared divider
  output div_ctl_t           div_ctl,
  output logic [ORDER_W-1:0] div_dividend,
  output logic [NW-1:0]      div_divisor,
  input  logic               div_done,
  input  logic [ORDER_W-1:0] div_quot,
  input  logic [NW-1:0]      div_rem,
  // result
  input  logic               out_free,
  output logic               res_load,
  output res_t               res
);

  localparam int CW       = (NW > EW) ? NW : EW;
  localparam int SHORT_SH = ORDER_W - NW;
  localparam int PROD_W   = ORDER_W + NW;

  state_t               state_r, state_nxt;
  op_t                  op_r, op_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [VAL_W-1:0]     val_r, val_nxt;
  logic [MASK_W-1:0]    mask_r, mask_nxt;
  logic [NW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        k_r, k_nxt;
  logic [NW-1:0]        len_r, len_nxt;
  logic [NW-1:0]        cyc_r, cyc_nxt;
  logic [NW-1:0]        gb_r, gb_nxt;
  logic [ORDER_W-1:0]   acc_r, acc_nxt;
  logic                 sat_r, sat_nxt;
  logic [EW-1:0]        carry_r, carry_nxt;
  logic [PROD_W-1:0]    prod_r, prod_nxt;
  logic [VAL_W-1:0]     rd_r, rd_nxt;
  logic [MAX_BELLS-1:0] visited_r, visited_nxt;

  logic [CW-1:0]        n_c;
  logic [CW-1:0]        idx_c;
  logic [CW-1:0]        chg_lim;
  logic                 pos_ok;
  logic                 nx_in;
  logic                 vis_scan;
  logic                 vis_nx;
  logic                 mbit;
  logic                 lcm_skip;
  logic                 walk_end;

  always_comb begin
    n_c      = CW'(n);
    idx_c    = CW'(idx_r);
    pos_ok   = CW'(pos_r) < n_c;
    chg_lim  = ((n_c - CW'(1)) < CW'(MASK_W)) ? (n_c - CW'(1)) : CW'(MASK_W);
    nx_in    = CW'(row_rd_data) < n_c;
    vis_scan = visited_r[idx_r[IW-1:0]];
    vis_nx   = visited_r[row_rd_data[IW-1:0]];
    mbit     = mask_r[4'(idx_r)];
    // a fixed point or a saturated order leaves the accumulator alone
    lcm_skip = sat_r || (len_r == NW'(1));
    walk_end = !nx_in || vis_nx;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        case (op_r)
          OP_READ:    state_nxt = S_RD_CAP;
          OP_CHANGE:  state_nxt = S_CHG_LOAD;
          OP_INVERT:  state_nxt = S_INV_RD;
          OP_ANALYSE: state_nxt = S_AN_SCAN;
          default:    state_nxt = S_DONE;
        endcase
      end
      S_RD_CAP:   state_nxt = S_DONE;
      S_CHG_LOAD: state_nxt = S_CHG_RD;
      S_CHG_RD:   state_nxt = S_CHG_WR;
      S_CHG_WR:   state_nxt = (idx_c + CW'(1) == chg_lim) ? S_CHG_END : S_CHG_RD;
      S_CHG_END:  state_nxt = S_DONE;
      S_INV_RD:   state_nxt = S_INV_WR;
      S_INV_WR:   state_nxt = (idx_c + CW'(1) == n_c) ? S_CPY_RD : S_INV_RD;
      S_CPY_RD:   state_nxt = S_CPY_WR;
      S_CPY_WR:   state_nxt = (idx_c + CW'(1) == n_c) ? S_DONE : S_CPY_RD;
      S_AN_SCAN: begin
        if (idx_c == n_c) begin
          state_nxt = S_DONE;
        end else if (!vis_scan) begin
          state_nxt = S_AN_STEP;
        end
      end
      S_AN_STEP:  state_nxt = S_AN_NEXT;
      S_AN_NEXT:  state_nxt = walk_end ? S_LCM : S_AN_STEP;
      S_LCM: begin
        if (lcm_skip || acc_r == ORDER_W'(1)) begin
          state_nxt = S_AN_SCAN;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD:      if (div_done && div_rem == '0) state_nxt = S_QUO;
      S_QUO:      if (div_done) state_nxt = S_CHK;
      S_CHK:      state_nxt = S_AN_SCAN;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs to the stores, the divider and the result register
  always_comb begin
    in_ready     = 1'b0;
    row_clear    = 1'b0;
    row_wr_en    = 1'b0;
    row_wr_addr  = idx_r[IW-1:0];
    row_wr_data  = carry_r;
    row_rd_addr  = '0;
    tmp_clear    = 1'b0;
    tmp_wr_en    = 1'b0;
    tmp_wr_addr  = row_rd_data[IW-1:0];
    tmp_wr_data  = EW'(idx_r);
    tmp_rd_addr  = idx_r[IW-1:0];
    div_ctl      = '0;
    div_dividend = acc_r;
    div_divisor  = len_r;
    res_load     = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        case (op_r)
          OP_IDENTITY: row_clear = 1'b1;
          OP_WRITE: begin
            row_wr_en   = pos_ok;
            row_wr_addr = IW'(pos_r);
            row_wr_data = EW'(val_r);
          end
          OP_READ:   row_rd_addr = IW'(pos_r);
          OP_INVERT: tmp_clear = 1'b1;
          default: ;
        endcase
      end
      S_CHG_RD: row_rd_addr = idx_r[IW-1:0] + IW'(1);
      S_CHG_WR: begin
        row_wr_en   = 1'b1;
        row_wr_data = mbit ? row_rd_data : carry_r;
      end
      S_CHG_END: row_wr_en = 1'b1;
      S_INV_RD:  row_rd_addr = idx_r[IW-1:0];
      S_INV_WR:  tmp_wr_en = nx_in;
      S_CPY_WR: begin
        row_wr_en   = 1'b1;
        row_wr_data = tmp_rd_data;
      end
      S_AN_STEP: row_rd_addr = k_r;
      S_LCM: begin
        if (!lcm_skip && acc_r != ORDER_W'(1)) begin
          div_ctl.start = 1'b1;
          div_ctl.steps = STEP_W'(ORDER_W);
        end
      end
      S_GCD: begin
        if (div_done) begin
          div_ctl.start = 1'b1;
          if (div_rem == '0) begin
            // gcd found, divide the accumulator by it
            div_divisor   = gb_r;
            div_ctl.steps = STEP_W'(ORDER_W);
          end else begin
            // small operands: left-align and run only the low bits
            div_dividend  = ORDER_W'(gb_r) << SHORT_SH;
            div_divisor   = div_rem;
            div_ctl.steps = STEP_W'(NW);
          end
        end
      end
      S_DONE: res_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    res.read_value = rd_r;
    res.perm_order = (op_r == OP_ANALYSE) ? acc_r : '0;
    res.is_even    = (op_r == OP_ANALYSE) ? ~(n[0] ^ cyc_r[0]) : 1'b0;
  end

  // datapath
  always_comb begin
    op_nxt      = op_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    mask_nxt    = mask_r;
    idx_nxt     = idx_r;
    k_nxt       = k_r;
    len_nxt     = len_r;
    cyc_nxt     = cyc_r;
    gb_nxt      = gb_r;
    acc_nxt     = acc_r;
    sat_nxt     = sat_r;
    carry_nxt   = carry_r;
    prod_nxt    = prod_r;
    rd_nxt      = rd_r;
    visited_nxt = visited_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = op_t'(in_op);
          pos_nxt  = in_position;
          val_nxt  = in_bell_value;
          mask_nxt = in_swap_mask;
        end
      end
      S_EXEC: begin
        rd_nxt  = '0;
        idx_nxt = '0;
        if (op_r == OP_ANALYSE) begin
          visited_nxt = '0;
          acc_nxt     = ORDER_W'(1);
          sat_nxt     = 1'b0;
          cyc_nxt     = '0;
        end
      end
      S_RD_CAP:   rd_nxt = pos_ok ? row_rd_data[VAL_W-1:0] : '0;
      S_CHG_LOAD: carry_nxt = row_rd_data;
      S_CHG_WR: begin
        // the carried bell keeps moving right while swaps continue
        if (!mbit) carry_nxt = row_rd_data;
        idx_nxt = idx_r + NW'(1);
      end
      S_INV_WR:   idx_nxt = (idx_c + CW'(1) == n_c) ? '0 : idx_r + NW'(1);
      S_CPY_WR:   idx_nxt = idx_r + NW'(1);
      S_AN_SCAN: begin
        if (idx_c != n_c) begin
          if (vis_scan) begin
            idx_nxt = idx_r + NW'(1);
          end else begin
            k_nxt   = idx_r[IW-1:0];
            len_nxt = '0;
          end
        end
      end
      S_AN_STEP: begin
        visited_nxt[k_r] = 1'b1;
        len_nxt          = len_r + NW'(1);
      end
      S_AN_NEXT: begin
        if (walk_end) begin
          cyc_nxt = cyc_r + NW'(1);
        end else begin
          k_nxt = row_rd_data[IW-1:0];
        end
      end
      S_LCM: begin
        if (!lcm_skip) begin
          if (acc_r == ORDER_W'(1)) begin
            acc_nxt = ORDER_W'(len_r);
          end else begin
            gb_nxt = len_r;
          end
        end
      end
      S_GCD:      if (div_done && div_rem != '0) gb_nxt = div_rem;
      S_QUO:      if (div_done) prod_nxt = PROD_W'(div_quot) * PROD_W'(len_r);
      S_CHK: begin
        if (|prod_r[PROD_W-1:ORDER_W]) begin
          sat_nxt = 1'b1;
          acc_nxt = ORDER_MAX;
        end else begin
          acc_nxt = prod_r[ORDER_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      visited_r <= '0;
    end else begin
      state_r   <= state_nxt;
      visited_r <= visited_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    mask_r  <= mask_nxt;
    idx_r   <= idx_nxt;
    k_r     <= k_nxt;
    len_r   <= len_nxt;
    cyc_r   <= cyc_nxt;
    gb_r    <= gb_nxt;
    acc_r   <= acc_nxt;
    sat_r   <= sat_nxt;
    carry_r <= carry_nxt;
    prod_r  <= prod_nxt;
    rd_r    <= rd_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/permutation_row_engine.sv @@
`default_nettype none

// Keeps one row of n bells (n = bell_count clamped to 2..MAX_BELLS) and runs one
// operation per input word: reset to rounds, write or read a place, apply a change
// (mask bit i swaps places i and i+1, lowest first), invert, or analyse (order as lcm
// of cycle lengths saturating at 65535, parity, and rounds flag). Every word gives
// exactly one result word, and in_ready stays low until the current word is finished.
// Analyse visits every place once through the row store's single registered read
// port (a scan step per place, a read step and a follow step per element, and two
// more steps per cycle found), and each cycle longer than one with an unsaturated
// order, once the accumulator is above one, runs through the shared restoring
// divider: a full-width division for the first gcd remainder, a short left-aligned
// one for each further remainder, a full-width one for the quotient, then a range
// check. A finished result waits in the output register; the next word is accepted
// as soon as the sequencer is back in idle.

module permutation_row_engine import prow_pkg::*; #(
  parameter int MAX_BELLS = 16
) (
  input  logic clk,
  input  logic rst_n,
  prow_in_if.sink    in_ch,
  prow_out_if.source out_ch,
  prow_cfg_if.sink   cfg_ch
);

  localparam int IW = (MAX_BELLS > 1) ? $clog2(MAX_BELLS) : 1;
  localparam int EW = (IW > VAL_W) ? IW : VAL_W;
  localparam int NW = $clog2(MAX_BELLS + 1);

  logic [BC_W-1:0]      bell_count_r;
  logic [BC_W:0]        bc_ext;
  logic [BC_W:0]        n_full;
  logic [NW-1:0]        n;

  logic                 row_clear, row_wr_en;
  logic [IW-1:0]        row_wr_addr, row_rd_addr;
  logic [EW-1:0]        row_wr_data, row_rd_data;
  logic [MAX_BELLS-1:0] row_mism;

  logic                 tmp_clear, tmp_wr_en;
  logic [IW-1:0]        tmp_wr_addr, tmp_rd_addr;
  logic [EW-1:0]        tmp_wr_data, tmp_rd_data;

  div_ctl_t             div_ctl;
  logic [ORDER_W-1:0]   div_dividend, div_quot;
  logic [NW-1:0]        div_divisor, div_rem;
  logic                 div_done;

  logic                 out_free;
  logic                 res_load;
  res_t                 res;
  logic                 row_ident;

  logic                 out_valid_r;
  res_t                 out_res_r;
  logic                 out_ident_r;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bell_count_r <= BELL_COUNT_RST;
    end else if (cfg_ch.valid) begin
      bell_count_r <= cfg_ch.bell_count;
    end
  end

  always_comb begin
    bc_ext = {1'b0, bell_count_r};
    if (bc_ext < (BC_W+1)'(MIN_BELLS)) begin
      n_full = (BC_W+1)'(MIN_BELLS);
    end else if (bc_ext > (BC_W+1)'(MAX_BELLS)) begin
      n_full = (BC_W+1)'(MAX_BELLS);
    end else begin
      n_full = bc_ext;
    end
    n = NW'(n_full);
  end

  // rounds when no place below n holds a foreign bell
  always_comb begin
    row_ident = 1'b1;
    for (int i = 0; i < MAX_BELLS; i++) begin
      if (row_mism[i] && (NW'(i) < n)) row_ident = 1'b0;
    end
  end

  prow_seq #(
    .MAX_BELLS (MAX_BELLS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_op         (in_ch.op),
    .in_position   (in_ch.position),
    .in_bell_value (in_ch.bell_value),
    .in_swap_mask  (in_ch.swap_mask),
    .n             (n),
    .row_clear     (row_clear),
    .row_wr_en     (row_wr_en),
    .row_wr_addr   (row_wr_addr),
    .row_wr_data   (row_wr_data),
    .row_rd_addr   (row_rd_addr),
    .row_rd_data   (row_rd_data),
    .tmp_clear     (tmp_clear),
    .tmp_wr_en     (tmp_wr_en),
    .tmp_wr_addr   (tmp_wr_addr),
    .tmp_wr_data   (tmp_wr_data),
    .tmp_rd_addr   (tmp_rd_addr),
    .tmp_rd_data   (tmp_rd_data),
    .div_ctl       (div_ctl),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_done      (div_done),
    .div_quot      (div_quot),
    .div_rem       (div_rem),
    .out_free      (out_free),
    .res_load      (res_load),
    .res           (res)
  );

  prow_store #(
    .MAX_BELLS (MAX_BELLS)
  ) u_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (row_clear),
    .wr_en   (row_wr_en),
    .wr_addr (row_wr_addr),
    .wr_data (row_wr_data),
    .rd_addr (row_rd_addr),
    .rd_data (row_rd_data),
    .mism    (row_mism)
  );

  prow_store #(
    .MAX_BELLS (MAX_BELLS)
  ) u_tmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (tmp_clear),
    .wr_en   (tmp_wr_en),
    .wr_addr (tmp_wr_addr),
    .wr_data (tmp_wr_data),
    .rd_addr (tmp_rd_addr),
    .rd_data (tmp_rd_data),
    .mism    ()
  );

  prow_div #(
    .DIVR_W (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // output word register
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r   <= res;
      out_ident_r <= row_ident;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_value  = out_res_r.read_value;
  assign out_ch.perm_order  = out_res_r.perm_order;
  assign out_ch.is_even     = out_res_r.is_even;
  assign out_ch.is_identity = out_ident_r;

endmodule

`default_nettype wire

@@ tb/sv/tb_permutation_row_engine.sv @@
`timescale 1ns / 1ps

module tb_permutation_row_engine;
  import prow_pkg::*;

  localparam int ROW_LEN = 16;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  bell_value;
    logic [MASK_W-1:0] swap_mask;
  } bell_word_t;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic [ORDER_W-1:0] perm_order;
    logic               is_even;
    logic               is_identity;
  } row_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  prow_in_if  in_ch ();
  prow_out_if out_ch ();
  prow_cfg_if cfg_ch ();

  permutation_row_engine #(.MAX_BELLS(ROW_LEN)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mirror of the block's row and bell count
  logic [VAL_W-1:0] row_q [ROW_LEN];
  logic [BC_W-1:0]  bell_count_q;

  bell_word_t  pending_words[$];
  row_report_t expected_reports[$];
  bell_word_t  cur_word;
  logic        word_live;
  logic        calm;
  int unsigned err_count;
  int unsigned cycle_count;

  function automatic int unsigned bells_in_use();
    int unsigned n;
    n = bell_count_q;
    if (n < MIN_BELLS) n = MIN_BELLS;
    if (n > ROW_LEN) n = ROW_LEN;
    return n;
  endfunction

  function automatic row_report_t apply_row_op(bell_word_t w);
    row_report_t      r;
    int unsigned      n, i, k, nx, len, cycles, acc, a, b, t, l;
    logic [VAL_W-1:0] tmp [ROW_LEN];
    logic [VAL_W-1:0] sw;
    logic [ROW_LEN-1:0] seen;
    logic             sat, stop;
    r = '0;
    n = bells_in_use();
    case (w.op)
      OP_IDENTITY: begin
        for (i = 0; i < ROW_LEN; i++) row_q[i] = VAL_W'(i);
      end
      OP_WRITE: begin
        if (w.position < n) row_q[w.position] = w.bell_value;
      end
      OP_READ: begin
        if (w.position < n) r.read_value = row_q[w.position];
      end
      OP_CHANGE: begin
        // swaps go lowest place first, so adjacent bits chain
        for (i = 0; i + 1 < n && i < MASK_W; i++) begin
          if (w.swap_mask[i]) begin
            sw = row_q[i];
            row_q[i] = row_q[i+1];
            row_q[i+1] = sw;
          end
        end
      end
      OP_INVERT: begin
        for (i = 0; i < ROW_LEN; i++) tmp[i] = VAL_W'(i);
        for (i = 0; i < n; i++)
          if (row_q[i] < n) tmp[row_q[i]] = VAL_W'(i);
        for (i = 0; i < n; i++) row_q[i] = tmp[i];
      end
      OP_ANALYSE: begin
        seen = '0;
        acc = 1;
        sat = 1'b0;
        cycles = 0;
        for (i = 0; i < n; i++) begin
          if (!seen[i]) begin
            k = i;
            len = 0;
            stop = 1'b0;
            while (!stop) begin
              seen[k] = 1'b1;
              len++;
              nx = row_q[k];
              if (nx >= n) begin
                stop = 1'b1;
              end else begin
                k = nx;
                if (seen[k]) stop = 1'b1;
              end
            end
            cycles++;
            if (!sat) begin
              a = acc;
              b = len;
              while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
              end
              l = (acc / a) * len;
              if (l > ORDER_MAX) begin
                sat = 1'b1;
                acc = ORDER_MAX;
              end else begin
                acc = l;
              end
            end
          end
        end
        r.perm_order = ORDER_W'(acc);
        r.is_even = ((n - cycles) % 2) == 0;
      end
      default: begin
      end
    endcase
    r.is_identity = 1'b1;
    for (i = 0; i < n; i++)
      if (row_q[i] != i) r.is_identity = 1'b0;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      word_live = 1'b0;
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_reports.push_back(apply_row_op(cur_word));
        word_live = 1'b0;
      end
      if (!word_live && pending_words.size() != 0 && (calm || $urandom_range(99) >= 33)) begin
        cur_word = pending_words.pop_front();
        word_live = 1'b1;
        in_ch.op <= cur_word.op;
        in_ch.position <= cur_word.position;
        in_ch.bell_value <= cur_word.bell_value;
        in_ch.swap_mask <= cur_word.swap_mask;
      end
      in_ch.valid <= word_live;
    end
  end

  // monitor
  always @(posedge clk) begin
    row_report_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result word with nothing expected");
          err_count++;
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_ch.read_value);
            err_count++;
          end
          if (out_ch.perm_order !== want.perm_order) begin
            $error("perm_order: expected %0d, got %0d", want.perm_order, out_ch.perm_order);
            err_count++;
          end
          if (out_ch.is_even !== want.is_even) begin
            $error("is_even: expected %0d, got %0d", want.is_even, out_ch.is_even);
            err_count++;
          end
          if (out_ch.is_identity !== want.is_identity) begin
            $error("is_identity: expected %0d, got %0d", want.is_identity,
                   out_ch.is_identity);
            err_count++;
          end
        end
      end
      out_ch.ready <= calm || $urandom_range(99) >= 33;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_word(logic [OP_W-1:0] op, int unsigned pos, int unsigned val,
                           int unsigned mask);
    bell_word_t w;
    w.op = op;
    w.position = POS_W'(pos);
    w.bell_value = VAL_W'(val);
    w.swap_mask = MASK_W'(mask);
    pending_words.push_back(w);
  endtask

  // mostly a bell that exists in the current row length
  function automatic int unsigned pick_bell();
    if ($urandom_range(99) < 80) return $urandom_range(bells_in_use() - 1);
    return $urandom_range(15);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || expected_reports.size() != 0);
  endtask

  task automatic write_bell_count(logic [BC_W-1:0] value);
    wait_drained();
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.bell_count <= value;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    bell_count_q = value;
    @(negedge clk);
  endtask

  task automatic queue_random(int unsigned count);
    int unsigned made, n, i, j, steps, tv;
    int unsigned order [ROW_LEN];
    made = 0;
    while (made < count) begin
      n = bells_in_use();
      if ($urandom_range(99) < 70) begin
        // scramble from rounds, then look at the row
        push_word(OP_IDENTITY, 0, 0, 0);
        made++;
        if ($urandom_range(99) < 25) begin
          for (i = 0; i < n; i++) order[i] = i;
          for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tv = order[i];
            order[i] = order[j];
            order[j] = tv;
          end
          for (i = 0; i < n; i++) push_word(OP_WRITE, i, order[i], 0);
          made += n;
        end
        steps = $urandom_range(1, 6);
        for (i = 0; i < steps; i++) push_word(OP_CHANGE, 0, 0, $urandom_range(32767));
        made += steps;
        if ($urandom_range(99) < 20) begin
          push_word(OP_WRITE, $urandom_range(15), pick_bell(), 0);
          made++;
        end
        if ($urandom_range(99) < 50) begin
          push_word(OP_INVERT, 0, 0, 0);
          made++;
        end
        push_word(OP_ANALYSE, $urandom_range(15), $urandom_range(15), $urandom_range(32767));
        made++;
        steps = $urandom_range(3);
        for (i = 0; i < steps; i++) push_word(OP_READ, $urandom_range(15), 0, 0);
        made += steps;
      end else begin
        steps = $urandom_range(1, 4);
        for (i = 0; i < steps; i++)
          push_word(OP_W'($urandom_range(7)), $urandom_range(15), pick_bell(),
                    $urandom_range(32767));
        made += steps;
      end
    end
  endtask

  initial begin
    int unsigned ph;
    logic [BC_W-1:0] phase_cfg [10];
    phase_cfg = '{5'd0, 5'd2, 5'd31, 5'd7, 5'd16, 5'd1, 5'd12, 5'd17, 5'd0, 5'd16};
    phase_cfg[8] = BC_W'($urandom_range(31));
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.position = '0;
    in_ch.bell_value = '0;
    in_ch.swap_mask = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.bell_count = '0;
    calm = 1'b0;
    err_count = 0;
    cycle_count = 0;
    word_live = 1'b0;
    bell_count_q = BELL_COUNT_RST;
    for (int i = 0; i < ROW_LEN; i++) row_q[i] = VAL_W'(i);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // full row after reset
    push_word(OP_ANALYSE, 0, 0, 0);
    push_word(OP_READ, 0, 0, 0);
    push_word(OP_READ, 15, 0, 0);
    push_word(OP_CHANGE, 0, 0, 15'h7FFF);
    push_word(OP_READ, 15, 0, 0);
    push_word(OP_ANALYSE, 0, 0, 0);
    push_word(OP_INVERT, 0, 0, 0);
    push_word(OP_ANALYSE, 0, 0, 0);
    push_word(OP_CHANGE, 15, 15, 0);
    push_word(OP_WRITE, 0, 15, 0);
    push_word(OP_INVERT, 0, 0, 0);
    push_word(OP_ANALYSE, 0, 0, 0);
    push_word(OP_SPARE_6, 15, 15, 15'h7FFF);
    push_word(OP_SPARE_7, 0, 0, 0);
    push_word(OP_IDENTITY, 0, 0, 0);
    push_word(OP_WRITE, 15, 0, 0);
    push_word(OP_WRITE, 0, 15, 0);
    push_word(OP_ANALYSE, 0, 0, 0);

    // shortest row: bell values and places past the end
    write_bell_count(phase_cfg[0]);
    push_word(OP_WRITE, 1, 15, 0);
    push_word(OP_READ, 1, 0, 0);
    push_word(OP_ANALYSE, 0, 0, 0);
    push_word(OP_INVERT, 0, 0, 0);
    push_word(OP_WRITE, 9, 3, 0);
    push_word(OP_READ, 9, 0, 0);
    push_word(OP_CHANGE, 0, 0, 15'h7FFF);
    push_word(OP_IDENTITY, 0, 0, 0);

    for (ph = 0; ph < 10; ph++) begin
      if (ph != 0) write_bell_count(phase_cfg[ph]);
      calm = (ph == 4);
      queue_random(115);
    end

    wait_drained();
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
